FILE: rtl/mseu_pkg.sv
package mseu_pkg;

	// data memory depth in words, a power of two
	localparam int MEM_WORDS = 1024;
	localparam int MEM_AW    = $clog2(MEM_WORDS);

	typedef enum logic [4:0] {
		OP_NOP     = 5'd0,
		OP_ADD     = 5'd1,
		OP_ADDI    = 5'd2,
		OP_AND     = 5'd3,
		OP_BEQ     = 5'd4,
		OP_BGTZ    = 5'd5,
		OP_BLEZ    = 5'd6,
		OP_BNE     = 5'd7,
		OP_DIV     = 5'd8,
		OP_J       = 5'd9,
		OP_JR      = 5'd10,
		OP_LUI     = 5'd11,
		OP_LW      = 5'd12,
		OP_MFHI    = 5'd13,
		OP_MFLO    = 5'd14,
		OP_MULT    = 5'd15,
		OP_OR      = 5'd16,
		OP_ROTR    = 5'd17,
		OP_SLL     = 5'd18,
		OP_SLT     = 5'd19,
		OP_SRL     = 5'd20,
		OP_SUB     = 5'd21,
		OP_SW      = 5'd22,
		OP_SYSCALL = 5'd23,
		OP_XOR     = 5'd24
	} op_t;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_MISALIGNED = 2'd1;
	localparam logic [1:0] ST_DIVZERO    = 2'd2;

	typedef struct packed {
		logic [4:0]         opcode;
		logic [4:0]         dest_reg;
		logic [4:0]         src_a_reg;
		logic [4:0]         src_b_reg;
		logic signed [15:0] imm_value;
		logic [4:0]         shift_amount;
		logic [25:0]        jump_target;
		logic [31:0]        cur_index;
	} item_t;

	typedef struct packed {
		logic load;
		logic rd_regs;
		logic exec;
		logic mem_wb;
		logic mul_wb;
		logic div_step;
		logic div_wb;
		logic out_load;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic go_mem;
		logic go_mul;
		logic go_div;
		logic div_last;
		logic clr_last;
	} sts_t;

endpackage

FILE: rtl/mseu_dp.sv
module mseu_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  mseu_pkg::cmd_t cmd,
	output mseu_pkg::sts_t sts,
	input  mseu_pkg::item_t in_item,
	output logic [31:0]    next_index,
	output logic [1:0]     status
);
	import mseu_pkg::*;

	item_t it_q;

	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] ra_data_q, rb_data_q;
	logic        ra_ok_q, rb_ok_q;
	logic        rf_we;
	logic [31:0] rf_wd;

	logic [31:0] dm_mem [MEM_WORDS];
	logic [31:0] dm_rdata_q;
	logic        dm_we;
	logic [MEM_AW-1:0] dm_wa;
	logic [31:0] dm_wd;
	logic [MEM_AW-1:0] clr_idx_q;

	logic [31:0] hi_q, lo_q;
	logic [63:0] prod_s1;

	logic [31:0] dvd_q, dvs_q, rem_q;
	logic [4:0]  cnt_q;
	logic        neg_quo_q, neg_rem_q;
	logic [32:0] shifted, diff;

	logic [31:0] a, b, imm_x, addr, alu_res, br_tgt, nxt;
	logic [63:0] rot;
	logic        wr_alu, aligned;
	logic [1:0]  st;
	logic [31:0] pend_next_q;
	logic [1:0]  pend_sts_q;
	op_t         op;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= in_item;
		end
	end

	assign op      = op_t'(it_q.opcode);
	assign a       = ra_ok_q ? ra_data_q : '0;
	assign b       = rb_ok_q ? rb_data_q : '0;
	assign imm_x   = {{16{it_q.imm_value[15]}}, it_q.imm_value};
	assign addr    = a + imm_x;
	assign aligned = (addr[1:0] == 2'b00);
	assign br_tgt  = it_q.cur_index + imm_x;
	assign rot     = {b, b} >> it_q.shift_amount;

	always_comb begin
		alu_res = '0;
		wr_alu  = 1'b1;
		nxt     = it_q.cur_index;
		st      = ST_OK;
		case (op)
			OP_ADD:  alu_res = a + b;
			OP_ADDI: alu_res = addr;
			OP_AND:  alu_res = a & b;
			OP_OR:   alu_res = a | b;
			OP_XOR:  alu_res = a ^ b;
			OP_SUB:  alu_res = a - b;
			OP_SLT:  alu_res = {31'd0, $signed(a) < $signed(b)};
			OP_SLL:  alu_res = b << it_q.shift_amount;
			OP_SRL:  alu_res = b >> it_q.shift_amount;
			OP_ROTR: alu_res = rot[31:0];
			OP_LUI:  alu_res = {it_q.imm_value, 16'd0};
			OP_MFHI: alu_res = hi_q;
			OP_MFLO: alu_res = lo_q;
			OP_BEQ: begin
				wr_alu = 1'b0;
				if (a == b) nxt = br_tgt;
			end
			OP_BNE: begin
				wr_alu = 1'b0;
				if (a != b) nxt = br_tgt;
			end
			OP_BGTZ: begin
				wr_alu = 1'b0;
				if (!a[31] && a != '0) nxt = br_tgt;
			end
			OP_BLEZ: begin
				wr_alu = 1'b0;
				if (a[31] || a == '0) nxt = br_tgt;
			end
			OP_J: begin
				wr_alu = 1'b0;
				nxt    = {6'd0, it_q.jump_target};
			end
			OP_JR: begin
				wr_alu = 1'b0;
				nxt    = a;
			end
			OP_DIV: begin
				wr_alu = 1'b0;
				if (b == '0) st = ST_DIVZERO;
			end
			OP_LW, OP_SW: begin
				wr_alu = 1'b0;
				if (!aligned) st = ST_MISALIGNED;
			end
			default: wr_alu = 1'b0;
		endcase
	end

	assign sts.go_mem   = (op == OP_LW) && aligned;
	assign sts.go_mul   = (op == OP_MULT);
	assign sts.go_div   = (op == OP_DIV) && (b != '0);
	assign sts.div_last = (cnt_q == 5'd31);
	assign sts.clr_last = (clr_idx_q == MEM_AW'(MEM_WORDS - 1));

	// register file, register zero never written
	assign rf_we = (it_q.dest_reg != 5'd0) && ((cmd.exec && wr_alu) || cmd.mem_wb);
	assign rf_wd = cmd.mem_wb ? dm_rdata_q : alu_res;

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[it_q.dest_reg] <= rf_wd;
		if (cmd.rd_regs) begin
			ra_data_q <= rf_mem[it_q.src_a_reg];
			rb_data_q <= rf_mem[it_q.src_b_reg];
			ra_ok_q   <= rf_vld_q[it_q.src_a_reg] && (it_q.src_a_reg != 5'd0);
			rb_ok_q   <= rf_vld_q[it_q.src_b_reg] && (it_q.src_b_reg != 5'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we) begin
			rf_vld_q[it_q.dest_reg] <= 1'b1;
		end
	end

	// data memory, one port shared by the clearing pass, stores and loads
	assign dm_we = cmd.clr_step || (cmd.exec && (op == OP_SW) && aligned);
	assign dm_wa = cmd.clr_step ? clr_idx_q : addr[MEM_AW+1:2];
	assign dm_wd = cmd.clr_step ? '0 : b;

	always_ff @(posedge clk) begin
		if (dm_we) dm_mem[dm_wa] <= dm_wd;
		if (cmd.exec) dm_rdata_q <= dm_mem[dm_wa];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// multiplier, product registered before hi/lo update
	always_ff @(posedge clk) begin
		if (cmd.exec) prod_s1 <= $signed(a) * $signed(b);
	end

	// restoring divider on magnitudes, one quotient bit per step
	assign shifted = {rem_q, dvd_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			dvd_q     <= a[31] ? -a : a;
			dvs_q     <= b[31] ? -b : b;
			rem_q     <= '0;
			neg_quo_q <= a[31] ^ b[31];
			neg_rem_q <= a[31];
		end else if (cmd.div_step) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				dvd_q <= {dvd_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				dvd_q <= {dvd_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hi_q  <= '0;
			lo_q  <= '0;
		end else begin
			if (cmd.exec) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
			if (cmd.mul_wb) begin
				hi_q <= prod_s1[63:32];
				lo_q <= prod_s1[31:0];
			end else if (cmd.div_wb) begin
				lo_q <= neg_quo_q ? -dvd_q : dvd_q;
				hi_q <= neg_rem_q ? -rem_q : rem_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pend_next_q <= nxt;
			pend_sts_q  <= st;
		end
		if (cmd.out_load) begin
			next_index <= pend_next_q;
			status     <= pend_sts_q;
		end
	end

endmodule

FILE: rtl/mseu_ctrl.sv
module mseu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output mseu_pkg::cmd_t cmd,
	input  mseu_pkg::sts_t sts
);
	import mseu_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MEMWB, S_MULWB, S_DIVRUN, S_DIVWB, S_FINISH
	} state_t;

	state_t state;
	logic   out_free;

	assign s_tready = (state == S_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.load     = s_tready && s_tvalid;
		cmd.clr_step = (state == S_CLEAR);
		cmd.rd_regs  = (state == S_READ);
		cmd.exec     = (state == S_EXEC);
		cmd.mem_wb   = (state == S_MEMWB);
		cmd.mul_wb   = (state == S_MULWB);
		cmd.div_step = (state == S_DIVRUN);
		cmd.div_wb   = (state == S_DIVWB);
		cmd.out_load = (state == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state    <= S_CLEAR;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			case (state)
				S_CLEAR:  if (sts.clr_last) state <= S_IDLE;
				S_IDLE:   if (s_tvalid) state <= S_READ;
				S_READ:   state <= S_EXEC;
				S_EXEC: begin
					if (sts.go_mem) state <= S_MEMWB;
					else if (sts.go_mul) state <= S_MULWB;
					else if (sts.go_div) state <= S_DIVRUN;
					else state <= S_FINISH;
				end
				S_MEMWB:  state <= S_FINISH;
				S_MULWB:  state <= S_FINISH;
				S_DIVRUN: if (sts.div_last) state <= S_DIVWB;
				S_DIVWB:  state <= S_FINISH;
				S_FINISH: if (out_free) state <= S_IDLE;
				default:  state <= S_IDLE;
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted while one is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before it was taken");

	a_div_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_last) |=> cmd.div_wb)
		else $error("divider result not written back after last step");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result valid without a result load");

endmodule

FILE: rtl/mips_subset_execute_unit.sv
// channel  direction  signals                          width
// s_       in         s_tvalid s_tready s_tdata s_tuser  96 + 5
// m_       out        m_tvalid m_tready m_tdata m_tuser  32 + 2
//
// after reset the data memory is cleared, with s_tready low until the clear ends
// one transaction at a time: read, execute, a write-back for aligned LW and
// MULT or one-bit-per-step divide and write-back for nonzero DIV, then finish
// a new transaction is taken while a result still waits in the output register
// a stalled result holds the finish step until m_tready frees the register
module mips_subset_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// dest_reg[4:0] src_a_reg[9:5] src_b_reg[14:10] imm_value[30:15]
	// shift_amount[35:31] jump_target[61:36] cur_index[93:62] zero[95:94]
	input  logic [95:0] s_tdata,
	// opcode[4:0]
	input  logic [4:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_index[31:0]
	output logic [31:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);
	import mseu_pkg::*;

	cmd_t  cmd;
	sts_t  sts;
	item_t in_item;

	assign in_item.opcode       = s_tuser;
	assign in_item.dest_reg     = s_tdata[4:0];
	assign in_item.src_a_reg    = s_tdata[9:5];
	assign in_item.src_b_reg    = s_tdata[14:10];
	assign in_item.imm_value    = s_tdata[30:15];
	assign in_item.shift_amount = s_tdata[35:31];
	assign in_item.jump_target  = s_tdata[61:36];
	assign in_item.cur_index    = s_tdata[93:62];

	mseu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mseu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_item    (in_item),
		.next_index (m_tdata),
		.status     (m_tuser)
	);

endmodule

FILE: dv/mips_subset_execute_unit_tb.sv
`timescale 1ns / 100ps

module mips_subset_execute_unit_tb;
	import mseu_pkg::*;

	typedef struct {
		logic [31:0] next_index;
		logic [1:0]  status;
	} outcome_t;

	// predicts the execute stage and holds the outcomes still to come
	class exec_scoreboard;
		logic [31:0] regs [32];
		logic [31:0] hi, lo;
		logic [31:0] dmem [MEM_WORDS];
		outcome_t    pending [$];
		int          errors;

		function void clear_state();
			foreach (regs[i]) regs[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			hi = '0;
			lo = '0;
			pending.delete();
			errors = 0;
		endfunction

		function void put_reg(logic [4:0] idx, logic [31:0] v);
			if (idx != 0) regs[idx] = v;
		endfunction

		function void note_input(item_t it);
			logic [31:0] a, b, imm, nxt, addr, q, r, ua, ub;
			logic [63:0] prod;
			logic [1:0]  st;
			outcome_t    o;
			a    = (it.src_a_reg == 0) ? 32'd0 : regs[it.src_a_reg];
			b    = (it.src_b_reg == 0) ? 32'd0 : regs[it.src_b_reg];
			imm  = {{16{it.imm_value[15]}}, it.imm_value};
			nxt  = it.cur_index;
			st   = ST_OK;
			case (it.opcode)
				OP_ADD:  put_reg(it.dest_reg, a + b);
				OP_ADDI: put_reg(it.dest_reg, a + imm);
				OP_AND:  put_reg(it.dest_reg, a & b);
				OP_OR:   put_reg(it.dest_reg, a | b);
				OP_XOR:  put_reg(it.dest_reg, a ^ b);
				OP_SUB:  put_reg(it.dest_reg, a - b);
				OP_SLT:  put_reg(it.dest_reg, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
				OP_SLL:  put_reg(it.dest_reg, b << it.shift_amount);
				OP_SRL:  put_reg(it.dest_reg, b >> it.shift_amount);
				OP_ROTR: put_reg(it.dest_reg, (it.shift_amount == 0) ? b :
					((b >> it.shift_amount) | (b << (6'd32 - it.shift_amount))));
				OP_LUI:  put_reg(it.dest_reg, {imm[15:0], 16'h0000});
				OP_MFHI: put_reg(it.dest_reg, hi);
				OP_MFLO: put_reg(it.dest_reg, lo);
				OP_BEQ:  if (a == b) nxt = it.cur_index + imm;
				OP_BNE:  if (a != b) nxt = it.cur_index + imm;
				OP_BGTZ: if ($signed(a) > 0) nxt = it.cur_index + imm;
				OP_BLEZ: if ($signed(a) <= 0) nxt = it.cur_index + imm;
				OP_J:    nxt = {6'd0, it.jump_target};
				OP_JR:   nxt = a;
				OP_MULT: begin
					prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					lo = prod[31:0];
					hi = prod[63:32];
				end
				OP_DIV: begin
					if (b == 0) begin
						st = ST_DIVZERO;
					end else begin
						ua = a[31] ? -a : a;
						ub = b[31] ? -b : b;
						q  = ua / ub;
						r  = ua % ub;
						if (a[31] != b[31]) q = -q;
						if (a[31]) r = -r;
						lo = q;
						hi = r;
					end
				end
				OP_LW, OP_SW: begin
					addr = a + imm;
					if (addr[1:0] != 0) st = ST_MISALIGNED;
					else if (it.opcode == OP_LW)
						put_reg(it.dest_reg, dmem[addr[MEM_AW+1:2]]);
					else
						dmem[addr[MEM_AW+1:2]] = b;
				end
				default: ;
			endcase
			o.next_index = nxt;
			o.status     = st;
			pending.push_back(o);
		endfunction

		task check_result(logic [31:0] nxt, logic [1:0] st);
			outcome_t o;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result next=%h status=%0d", nxt, st));
				return;
			end
			o = pending.pop_front();
			if (nxt !== o.next_index)
				report_mismatch($sformatf("next_index %h, want %h", nxt, o.next_index));
			if (st !== o.status)
				report_mismatch($sformatf("status %0d, want %0d", st, o.status));
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [4:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	exec_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	localparam int QUIET_LIMIT = 20000;

	mips_subset_execute_unit uut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// entered at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tuser  <= it.opcode;
		s_tdata  <= {2'b00, it.cur_index, it.jump_target, it.shift_amount, it.imm_value,
			it.src_b_reg, it.src_a_reg, it.dest_reg};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(it);
		@(negedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		it.opcode       = 5'($urandom_range(31));
		if ($urandom_range(9) < 9) it.opcode = 5'($urandom_range(24));
		it.dest_reg     = 5'($urandom_range(31));
		it.src_a_reg    = 5'($urandom_range(31));
		it.src_b_reg    = 5'($urandom_range(31));
		// mostly small or word-aligned offsets so that memory traffic succeeds
		case ($urandom_range(3))
			0: it.imm_value = 16'($urandom());
			1: it.imm_value = 16'($urandom_range(63) * 4);
			2: it.imm_value = $signed(16'($urandom_range(15))) - 16'sd8;
			default: it.imm_value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		endcase
		it.shift_amount = 5'($urandom_range(31));
		it.jump_target  = 26'($urandom());
		it.cur_index    = $urandom();
		return it;
	endfunction

	function automatic item_t mk(op_t op, int rd, int ra, int rb, int imm, int sa = 0);
		item_t it;
		it.opcode       = op;
		it.dest_reg     = 5'(rd);
		it.src_a_reg    = 5'(ra);
		it.src_b_reg    = 5'(rb);
		it.imm_value    = 16'(imm);
		it.shift_amount = 5'(sa);
		it.jump_target  = 26'h3ffffff;
		it.cur_index    = 32'hffff_fff0;
		return it;
	endfunction

	initial begin
		sb = new();
		sb.clear_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, divide corners, rotation by zero, misalignment
		send_item(mk(OP_LUI, 1, 0, 0, -32768));
		send_item(mk(OP_ADDI, 2, 0, 0, -1));
		send_item(mk(OP_ADDI, 0, 2, 0, 5));
		send_item(mk(OP_DIV, 3, 1, 2, 0));
		send_item(mk(OP_MFLO, 4, 0, 0, 0));
		send_item(mk(OP_MFHI, 5, 0, 0, 0));
		send_item(mk(OP_DIV, 0, 1, 0, 0));
		send_item(mk(OP_MULT, 0, 1, 1, 0));
		send_item(mk(OP_MFHI, 6, 0, 0, 0));
		send_item(mk(OP_ROTR, 7, 0, 2, 0, 0));
		send_item(mk(OP_ROTR, 7, 0, 1, 0, 31));
		send_item(mk(OP_SRL, 8, 0, 2, 0, 31));
		send_item(mk(OP_SLL, 9, 0, 2, 0, 31));
		send_item(mk(OP_SW, 0, 0, 2, 1));
		send_item(mk(OP_SW, 0, 0, 2, 2));
		send_item(mk(OP_SW, 0, 0, 2, 32764));
		send_item(mk(OP_LW, 10, 0, 0, 32764));
		send_item(mk(OP_SLT, 11, 1, 2, 0));
		send_item(mk(OP_BEQ, 0, 0, 0, 32767));
		send_item(mk(OP_BLEZ, 0, 1, 0, -32768));
		send_item(mk(OP_BGTZ, 0, 10, 0, 4));
		send_item(mk(OP_J, 0, 0, 0, 0));
		send_item(mk(OP_JR, 0, 2, 0, 0));
		send_item(mk(OP_SYSCALL, 0, 0, 0, 0));
		send_item(mk(op_t'(5'd31), 0, 0, 0, 0));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			repeat (270) send_item(random_item());
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule

FILE: sim.f
rtl/mseu_pkg.sv
rtl/mseu_dp.sv
rtl/mseu_ctrl.sv
rtl/mips_subset_execute_unit.sv
dv/mips_subset_execute_unit_tb.sv
